FILE: src/vof_pkg.sv
// shared types, constants and helpers for the vertical or-filter block
// no dependencies; every other file of the block but vof_ram uses this package
`default_nettype none

package vof_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int SIZE_W  = 11;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int LINE_W  = 2 * PIX_W;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

   localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd320;
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd240;
   localparam logic [SIZE_W-1:0] LIMIT_WIDTH  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] LIMIT_HEIGHT = SIZE_W'(MAX_HEIGHT);

   typedef struct packed {
      logic [CHAN_W-1:0] blue_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] red_in;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] red_out;
      logic [ROW_W-1:0]  out_row;
      logic [COL_W-1:0]  out_column;
      logic              run_last;
      logic              frame_last;
   } rsp_payload_type;

   // raster position of the beat on offer, with the row/column flags it needs
   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             single_row;
      logic             first_row;
      logic             second_row;
      logic             last_row;
      logic             end_col;
   } pos_type;

   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } size_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/vof_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module vof_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

FILE: src/vof_csr.sv
// apb register file: image width and height, with effective (clamped) sizes
// depends on vof_pkg
`default_nettype none

module vof_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [vof_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [vof_pkg::DATA_W-1:0]    pwdata,
   output logic      [vof_pkg::DATA_W-1:0]    prdata,
   output logic                               pready,
   output vof_pkg::size_type                  size_eff
);

   logic [vof_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [vof_pkg::SIZE_W-1:0] height_ff, height_in;
   logic                       wr_en;
   logic [vof_pkg::ADDR_W-1:0] reg_addr;

   // byte lanes below the word are ignored
   assign reg_addr = {paddr[vof_pkg::ADDR_W-1:2], 2'b00};
   assign wr_en    = psel && penable && pwrite;
   assign pready   = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (reg_addr)
            vof_pkg::REG_IMAGE_WIDTH:  width_in  = pwdata[vof_pkg::SIZE_W-1:0];
            vof_pkg::REG_IMAGE_HEIGHT: height_in = pwdata[vof_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= vof_pkg::RESET_WIDTH;
         height_ff <= vof_pkg::RESET_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (reg_addr)
         vof_pkg::REG_IMAGE_WIDTH:
            prdata = {{(vof_pkg::DATA_W-vof_pkg::SIZE_W){1'b0}}, width_ff};
         vof_pkg::REG_IMAGE_HEIGHT:
            prdata = {{(vof_pkg::DATA_W-vof_pkg::SIZE_W){1'b0}}, height_ff};
         default:
            prdata = '0;
      endcase
   end

   assign size_eff.width  = vof_pkg::clamp_size(width_ff, vof_pkg::LIMIT_WIDTH);
   assign size_eff.height = vof_pkg::clamp_size(height_ff, vof_pkg::LIMIT_HEIGHT);

endmodule

`default_nettype wire

FILE: src/vof_scan.sv
// raster column/row counters; gives the position of the pixel on offer
// depends on vof_pkg
`default_nettype none

module vof_scan (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  vof_pkg::size_type      size_eff,
   output vof_pkg::pos_type       pos
);

   logic [vof_pkg::COL_W-1:0]  col_ff, col_in;
   logic [vof_pkg::ROW_W-1:0]  row_ff, row_in;
   logic                       outside;
   logic [vof_pkg::SIZE_W-1:0] col_next;
   logic [vof_pkg::SIZE_W-1:0] row_next;

   // counters left beyond the frame by a size change restart the frame
   assign outside = ({1'b0, col_ff} >= size_eff.width) || ({1'b0, row_ff} >= size_eff.height);

   always_comb begin
      pos.column     = outside ? '0 : col_ff;
      pos.row        = outside ? '0 : row_ff;
      pos.single_row = (size_eff.height == vof_pkg::SIZE_W'(1));
      pos.first_row  = (pos.row == '0);
      pos.second_row = (pos.row == vof_pkg::ROW_W'(1));
      pos.last_row   = ({1'b0, pos.row} == size_eff.height - vof_pkg::SIZE_W'(1));
      pos.end_col    = ({1'b0, pos.column} == size_eff.width - vof_pkg::SIZE_W'(1));
   end

   assign col_next = {1'b0, pos.column} + vof_pkg::SIZE_W'(1);
   assign row_next = {1'b0, pos.row} + vof_pkg::SIZE_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= size_eff.width) begin
            col_in = '0;
            row_in = (row_next >= size_eff.height) ? '0 : row_next[vof_pkg::ROW_W-1:0];
         end else begin
            col_in = col_next[vof_pkg::COL_W-1:0];
            row_in = pos.row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/vof_filter.sv
// filter stage: takes line store data, forms up to two results per pixel,
// writes the line store back and holds the output register; depends on vof_pkg
`default_nettype none

module vof_filter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  vof_pkg::req_payload_type           req_payload,
   input  vof_pkg::pos_type                   pos,
   input  wire logic [vof_pkg::LINE_W-1:0]    ram_rdata,
   output logic                               ram_we,
   output logic      [vof_pkg::COL_W-1:0]     ram_waddr,
   output logic      [vof_pkg::LINE_W-1:0]    ram_wdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output vof_pkg::rsp_payload_type           rsp_payload
);

   logic                            accept;
   logic                            s1_valid_ff, s1_valid_in;
   logic                            phase_ff, phase_in;
   vof_pkg::pos_type                s1_pos_ff;
   logic [vof_pkg::PIX_W-1:0]       s1_cur_ff;
   logic                            fwd_ff;
   logic [vof_pkg::LINE_W-1:0]      fwd_data_ff;
   logic                            out_valid_ff, out_valid_in;
   vof_pkg::rsp_payload_type        out_data_ff;

   logic [vof_pkg::PIX_W-1:0]       prev_eff;
   logic [vof_pkg::PIX_W-1:0]       before_eff;
   logic [vof_pkg::PIX_W-1:0]       filt;
   logic                            emit_a;
   logic                            emit_b;
   logic                            has_result;
   logic                            out_load;
   logic                            retire;
   vof_pkg::rsp_payload_type        res;

   assign accept = req_valid && req_ready;

   // a read issued at the edge that writes the same entry gets the new data
   assign prev_eff   = fwd_ff ? fwd_data_ff[vof_pkg::PIX_W-1:0] : ram_rdata[vof_pkg::PIX_W-1:0];
   assign before_eff = fwd_ff ? fwd_data_ff[vof_pkg::LINE_W-1:vof_pkg::PIX_W]
                              : ram_rdata[vof_pkg::LINE_W-1:vof_pkg::PIX_W];

   assign filt = s1_pos_ff.second_row ? prev_eff : (before_eff | prev_eff | s1_cur_ff);

   // a: filtered pixel of the row above, b: the pixel itself passed through
   assign emit_a = !s1_pos_ff.single_row && !s1_pos_ff.first_row;
   assign emit_b = s1_pos_ff.single_row || s1_pos_ff.last_row;

   assign has_result = s1_valid_ff && (phase_ff || emit_a || emit_b);
   assign out_load   = has_result && (!out_valid_ff || rsp_ready);
   assign retire     = s1_valid_ff && (!has_result || (out_load && (phase_ff || !(emit_a && emit_b))));
   assign req_ready  = !s1_valid_ff || retire;

   always_comb begin
      if (emit_a && !phase_ff) begin
         {res.blue_out, res.green_out, res.red_out} = filt;
         res.out_row    = s1_pos_ff.row - vof_pkg::ROW_W'(1);
         res.run_last   = !emit_b;
         res.frame_last = 1'b0;
      end else begin
         {res.blue_out, res.green_out, res.red_out} = s1_cur_ff;
         res.out_row    = s1_pos_ff.row;
         res.run_last   = 1'b1;
         res.frame_last = s1_pos_ff.end_col;
      end
      res.out_column = s1_pos_ff.column;
   end

   assign ram_we    = retire;
   assign ram_waddr = s1_pos_ff.column;
   assign ram_wdata = {prev_eff, s1_cur_ff};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      phase_in    = phase_ff;
      if (retire) begin
         s1_valid_in = 1'b0;
         phase_in    = 1'b0;
      end else if (out_load) begin
         phase_in = 1'b1;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            fwd_ff <= ram_we && (ram_waddr == pos.column);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff   <= pos;
         s1_cur_ff   <= {req_payload.blue_in, req_payload.green_in, req_payload.red_in};
         fwd_data_ff <= ram_wdata;
      end
      if (out_load) begin
         out_data_ff <= res;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

`default_nettype wire

FILE: src/vertical_or_filter_rgb.sv
// top level of the vertical 3x1 or-filter over an rgb raster stream
// depends on vof_pkg, vof_csr, vof_scan, vof_filter and vof_ram
`default_nettype none

// Vertical or-filter: pixels enter in raster order, one beat per pixel, and each
// pixel of an interior row leaves as the per-channel or of itself and its
// neighbors above and below; first and last rows pass unchanged, and the beat
// at row y returns the finished pixel of row y-1 (a last-row beat also returns
// itself, a one-row image passes straight through). A pixel is taken every
// clock while the output is not stalled; a pixel on the last row gives two result
// beats and so holds the input while the single output register passes them on.
// An input beat goes through the line store read, then the output register,
// before its first result beat. Both previous lines live in one 48-bit wide,
// MAX_WIDTH deep memory read and written once per pixel. Image size is set
// over apb at 0x0 (width) and 0x4 (height) and may change only while idle.
module vertical_or_filter_rgb (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  vof_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output vof_pkg::rsp_payload_type           rsp_payload,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [vof_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [vof_pkg::DATA_W-1:0]    pwdata,
   output logic      [vof_pkg::DATA_W-1:0]    prdata,
   output logic                               pready
);

   vof_pkg::size_type            size_eff;
   vof_pkg::pos_type             pos;
   logic                         accept;
   logic [vof_pkg::LINE_W-1:0]   ram_rdata;
   logic                         ram_we;
   logic [vof_pkg::COL_W-1:0]    ram_waddr;
   logic [vof_pkg::LINE_W-1:0]   ram_wdata;

   assign accept = req_valid && req_ready;

   vof_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .size_eff (size_eff)
   );

   vof_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .size_eff (size_eff),
      .pos      (pos)
   );

   // line store: upper half the line before previous, lower half the previous line
   vof_ram #(
      .WIDTH (vof_pkg::LINE_W),
      .DEPTH (vof_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (pos.column),
      .rdata (ram_rdata)
   );

   vof_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .pos         (pos),
      .ram_rdata   (ram_rdata),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: bench/vertical_or_filter_rgb_tb.sv
// self-checking bench for the vertical rgb or-filter: random pixel frames over valid/ready,
// image size set over apb, every result beat checked against an in-bench filter prediction
// depends on vof_pkg and vertical_or_filter_rgb
module vertical_or_filter_rgb_tb;

   localparam int ITEM_TARGET    = 1950;
   localparam int QUIET_TAIL     = 250;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_HOLD      = 300;
   // the directed part loads 23 pixels, so this lands inside the pressure phase
   localparam int PRESSURE_AFTER = 30;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   vof_pkg::req_payload_type           req_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   vof_pkg::rsp_payload_type           rsp_payload;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [vof_pkg::ADDR_W-1:0]         paddr = '0;
   logic [vof_pkg::DATA_W-1:0]         pwdata = '0;
   logic [vof_pkg::DATA_W-1:0]         prdata;
   logic                               pready;

   // filter prediction state
   vof_pkg::req_payload_type           line_1up [vof_pkg::MAX_WIDTH];
   vof_pkg::req_payload_type           line_2up [vof_pkg::MAX_WIDTH];
   int                                 column_pos = 0;
   int                                 row_pos = 0;
   logic [vof_pkg::SIZE_W-1:0]         width_setting = vof_pkg::RESET_WIDTH;
   logic [vof_pkg::SIZE_W-1:0]         height_setting = vof_pkg::RESET_HEIGHT;
   vof_pkg::rsp_payload_type           filtered_due [$];

   vof_pkg::req_payload_type           pixels_to_send [$];
   int                                 items_loaded = 0;
   int                                 pixels_accepted = 0;
   int                                 errors = 0;
   int                                 quiet_cycles = 0;
   logic                               req_fire = 1'b0;
   logic                               quiet_tail = 1'b0;
   int                                 req_gap = 0;
   int                                 rsp_gap = 0;
   logic                               hold_used = 1'b0;

   vertical_or_filter_rgb dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int effective_size(input logic [vof_pkg::SIZE_W-1:0] v,
                                         input int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic vof_pkg::rsp_payload_type make_result(
      input vof_pkg::req_payload_type pix, input int row, input int col,
      input logic run_last, input logic frame_last);
      vof_pkg::rsp_payload_type r;
      r.blue_out   = pix.blue_in;
      r.green_out  = pix.green_in;
      r.red_out    = pix.red_in;
      r.out_row    = vof_pkg::ROW_W'(row);
      r.out_column = vof_pkg::COL_W'(col);
      r.run_last   = run_last;
      r.frame_last = frame_last;
      return r;
   endfunction

   function automatic string describe(input vof_pkg::rsp_payload_type r);
      return $sformatf("b=%h g=%h r=%h row=%0d col=%0d run_last=%b frame_last=%b",
                       r.blue_out, r.green_out, r.red_out, r.out_row, r.out_column,
                       r.run_last, r.frame_last);
   endfunction

   // one accepted pixel: advance the raster position and queue the finished pixels
   function automatic void or_filter_step(input vof_pkg::req_payload_type px);
      int w, h, x, y;
      logic end_col;
      vof_pkg::req_payload_type mid, up, res;
      w = effective_size(width_setting, vof_pkg::MAX_WIDTH);
      h = effective_size(height_setting, vof_pkg::MAX_HEIGHT);
      // a size change can leave the counters outside the frame: restart at the origin
      if (column_pos >= w || row_pos >= h) begin
         column_pos = 0;
         row_pos = 0;
      end
      x = column_pos;
      y = row_pos;
      end_col = (x == w - 1);
      if (h == 1) begin
         filtered_due.push_back(make_result(px, y, x, 1'b1, end_col));
      end else if (y > 0) begin
         mid = line_1up[x];
         if (y == 1) begin
            res = mid;
         end else begin
            up = line_2up[x];
            res.blue_in  = up.blue_in | mid.blue_in | px.blue_in;
            res.green_in = up.green_in | mid.green_in | px.green_in;
            res.red_in   = up.red_in | mid.red_in | px.red_in;
         end
         if (y == h - 1) begin
            filtered_due.push_back(make_result(res, y - 1, x, 1'b0, 1'b0));
            filtered_due.push_back(make_result(px, y, x, 1'b1, end_col));
         end else begin
            filtered_due.push_back(make_result(res, y - 1, x, 1'b1, 1'b0));
         end
      end
      line_2up[x] = line_1up[x];
      line_1up[x] = px;
      column_pos = x + 1;
      if (column_pos >= w) begin
         column_pos = 0;
         row_pos = y + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function automatic logic [vof_pkg::CHAN_W-1:0] random_channel();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return vof_pkg::CHAN_W'(1) << $urandom_range(0, vof_pkg::CHAN_W - 1);
         default: return vof_pkg::CHAN_W'($urandom);
      endcase
   endfunction

   function automatic vof_pkg::req_payload_type px(input logic [vof_pkg::CHAN_W-1:0] b,
                                                   input logic [vof_pkg::CHAN_W-1:0] g,
                                                   input logic [vof_pkg::CHAN_W-1:0] r);
      vof_pkg::req_payload_type p;
      p.blue_in  = b;
      p.green_in = g;
      p.red_in   = r;
      return p;
   endfunction

   task automatic send(input vof_pkg::req_payload_type p);
      pixels_to_send.push_back(p);
      items_loaded++;
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         send(px(random_channel(), random_channel(), random_channel()));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pixels_accepted != items_loaded || filtered_due.size() != 0) @(negedge clock);
      // row-0 pixels give no result but may still be in flight
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [vof_pkg::ADDR_W-1:0] addr,
                            input logic [vof_pkg::SIZE_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {(vof_pkg::DATA_W - vof_pkg::SIZE_W)'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == vof_pkg::REG_IMAGE_WIDTH) width_setting = value;
      else height_setting = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_size(input int w, input int h);
      wait_drained();
      csr_write(vof_pkg::REG_IMAGE_WIDTH, vof_pkg::SIZE_W'(w));
      csr_write(vof_pkg::REG_IMAGE_HEIGHT, vof_pkg::SIZE_W'(h));
   endtask

   // sender: one beat per pixel, with random idle bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold the beat until it is taken
      end else if (req_gap > 0) begin
         req_gap = req_gap - 1;
         req_valid <= 1'b0;
      end else if (pixels_to_send.size() == 0) begin
         req_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         req_gap = $urandom_range(0, 7);
         req_valid <= 1'b0;
      end else begin
         req_payload <= pixels_to_send.pop_front();
         req_valid <= 1'b1;
      end
   end

   // receiver: random stalls, plus one long hold-off so the block backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_used && pixels_accepted >= PRESSURE_AFTER) begin
         hold_used = 1'b1;
         rsp_gap = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      vof_pkg::rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            or_filter_step(req_payload);
            pixels_accepted = pixels_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (filtered_due.size() == 0) begin
               errors = errors + 1;
               $display("%0t: expected no beat, got %s", $time, describe(rsp_payload));
            end else begin
               want = filtered_due.pop_front();
               if (rsp_payload.blue_out !== want.blue_out ||
                   rsp_payload.green_out !== want.green_out ||
                   rsp_payload.red_out !== want.red_out ||
                   rsp_payload.out_row !== want.out_row ||
                   rsp_payload.out_column !== want.out_column ||
                   rsp_payload.run_last !== want.run_last ||
                   rsp_payload.frame_last !== want.frame_last) begin
                  errors = errors + 1;
                  $display("%0t: expected %s, got %s", $time, describe(want),
                           describe(rsp_payload));
               end
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      req_fire <= !reset && req_valid && req_ready;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int kind, w_a, h_a, we, he, n, col, row, w_b, h_b, frames;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 3x3 frame: first row passes, middle row ors, last row gives two beats per pixel
      set_size(3, 3);
      send(px(8'h01, 8'h02, 8'h04));
      send(px(8'hFF, 8'h00, 8'h00));
      send(px(8'h00, 8'h00, 8'h00));
      send(px(8'h10, 8'h20, 8'h40));
      send(px(8'h00, 8'hFF, 8'h00));
      send(px(8'h80, 8'h00, 8'h01));
      send(px(8'h00, 8'h00, 8'h00));
      send(px(8'h00, 8'h00, 8'hFF));
      send(px(8'hAA, 8'h55, 8'hAA));
      // zero width acts as one, single row passes straight through
      set_size(0, 1);
      send(px(8'hFF, 8'hFF, 8'hFF));
      send(px(8'h00, 8'h00, 8'h00));
      // two rows: no interior row at all
      set_size(2, 2);
      send(px(8'h55, 8'hAA, 8'h55));
      send(px(8'hAA, 8'h55, 8'hAA));
      send(px(8'h0F, 8'hF0, 8'h3C));
      send(px(8'hC3, 8'h0F, 8'hF0));
      // oversize height clamps; partial frame, then a height below the current row restarts
      set_size(4, 2047);
      send_random(6);
      set_size(2, 1);
      send_random(2);

      // pressure phase: the receiver hold-off starts in here
      set_size(6, 5);
      send_random(4 * 30);

      while (items_loaded < ITEM_TARGET) begin
         if (items_loaded >= ITEM_TARGET - QUIET_TAIL) quiet_tail = 1'b1;
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            w_a = $urandom_range(0, 12);
            h_a = $urandom_range(0, 8);
            set_size(w_a, h_a);
            send_random($urandom_range(1, 3) *
                        effective_size(vof_pkg::SIZE_W'(w_a), vof_pkg::MAX_WIDTH) *
                        effective_size(vof_pkg::SIZE_W'(h_a), vof_pkg::MAX_HEIGHT));
         end else begin
            if (kind < 9) begin
               w_a = $urandom_range(2, 10);
               h_a = $urandom_range(1, 6);
            end else if ($urandom_range(0, 1) == 0) begin
               case ($urandom_range(0, 2))
                  0: w_a = vof_pkg::MAX_WIDTH;
                  1: w_a = 2047;
                  default: w_a = $urandom_range(64, vof_pkg::MAX_WIDTH - 1);
               endcase
               case ($urandom_range(0, 2))
                  0: h_a = vof_pkg::MAX_HEIGHT;
                  1: h_a = 2047;
                  default: h_a = $urandom_range(1, vof_pkg::MAX_HEIGHT - 1);
               endcase
            end else begin
               w_a = $urandom_range(1, 2);
               h_a = $urandom_range(512, 2047);
            end
            we = effective_size(vof_pkg::SIZE_W'(w_a), vof_pkg::MAX_WIDTH);
            he = effective_size(vof_pkg::SIZE_W'(h_a), vof_pkg::MAX_HEIGHT);
            n = $urandom_range(1, (we * he - 1 < 100) ? we * he - 1 : 100);
            set_size(w_a, h_a);
            send_random(n);
            // cut the frame short: new size puts the counters outside the frame
            col = n % we;
            row = (n / we) % he;
            if (col > 0) begin
               w_b = $urandom_range(0, (col > 12) ? 12 : col);
               h_b = $urandom_range(1, 8);
            end else begin
               w_b = $urandom_range(1, 12);
               h_b = $urandom_range(1, (row > 8) ? 8 : row);
            end
            frames = $urandom_range(1, 2);
            set_size(w_b, h_b);
            send_random(frames * effective_size(vof_pkg::SIZE_W'(w_b), vof_pkg::MAX_WIDTH) *
                        effective_size(vof_pkg::SIZE_W'(h_b), vof_pkg::MAX_HEIGHT));
         end
      end

      wait_drained();
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
